[hdl/bgpmsp_pkg.sv]
// shared types and constants for the bgp message stream parser
`default_nettype none

package bgpmsp_pkg;

  // width of the running totals kept inside the block
  localparam int unsigned TotalWidth = 32;

  localparam logic [7:0] MarkerByte = 8'hff;
  localparam logic [15:0] HeaderLen = 16'd19;
  localparam logic [7:0] MaxPrefixLen = 8'd32;
  localparam logic [7:0] BgpVersion = 8'd4;

  localparam logic [7:0] TypeOpen = 8'd1;
  localparam logic [7:0] TypeUpdate = 8'd2;
  localparam logic [7:0] TypeNotify = 8'd3;
  localparam logic [7:0] TypeKeepalive = 8'd4;

  localparam logic [2:0] StOk = 3'd0;
  localparam logic [2:0] StBadMarker = 3'd1;
  localparam logic [2:0] StShortLen = 3'd2;
  localparam logic [2:0] StPrefixLen = 3'd3;
  localparam logic [2:0] StPrefixOver = 3'd4;
  localparam logic [2:0] StWdrawOver = 3'd5;
  localparam logic [2:0] StAttrOver = 3'd6;
  localparam logic [2:0] StBadVersion = 3'd7;

  // declared highest field first so that msg_type lands in the lowest bits
  typedef struct packed {
    logic [31:0] total_withdrawn;
    logic [31:0] total_nlri;
    logic [31:0] total_updates;
    logic [31:0] total_messages;
    logic [15:0] open_as;
    logic [7:0]  notify_subcode;
    logic [7:0]  notify_code;
    logic [15:0] nlri_count;
    logic [15:0] withdrawn_count;
    logic [2:0]  status;
    logic [15:0] payload_length;
    logic [7:0]  msg_type;
  } res_t;

  localparam int unsigned ResW = $bits(res_t);
  localparam int unsigned DataW = ((ResW + 7) / 8) * 8;
  localparam int unsigned PadW = DataW - ResW;

endpackage

`default_nettype wire

[hdl/bgpmsp_step.sv]
// per-byte parse state and the single-pass step logic that forms one result per message or fatal header error
`default_nettype none

module bgpmsp_step (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_vld_i,
  input  wire logic [7:0]         in_byte_i,
  output logic                    res_vld_o,
  output bgpmsp_pkg::res_t        res_o
);
  import bgpmsp_pkg::*;

  localparam logic [3:0] PhHeader = 4'd0;
  localparam logic [3:0] PhSkip   = 4'd1;
  localparam logic [3:0] PhOpen   = 4'd2;
  localparam logic [3:0] PhNotify = 4'd3;
  localparam logic [3:0] PhWlen   = 4'd4;
  localparam logic [3:0] PhWpfx   = 4'd5;
  localparam logic [3:0] PhAlen   = 4'd6;
  localparam logic [3:0] PhAttr   = 4'd7;
  localparam logic [3:0] PhNlri   = 4'd8;

  logic [3:0]  phase_q, phase_d;
  logic [15:0] idx_q, idx_d;
  logic [15:0] mlen_q, mlen_d;
  logic [7:0]  typ_q, typ_d;
  logic [15:0] wlen_q, wlen_d;
  logic [15:0] alen_q, alen_d;
  logic [2:0]  pleft_q, pleft_d;
  logic [15:0] wtally_q, wtally_d;
  logic [15:0] ntally_q, ntally_d;
  logic [2:0]  status_q, status_d;
  logic [15:0] code_q, code_d;
  logic [15:0] as_q, as_d;
  logic [TotalWidth-1:0] msg_tot_q, msg_tot_d;
  logic [TotalWidth-1:0] upd_tot_q, upd_tot_d;
  logic [TotalWidth-1:0] nlri_tot_q, nlri_tot_d;
  logic [TotalWidth-1:0] wdr_tot_q, wdr_tot_d;
  logic        halted_q, halted_d;

  logic [15:0] pos;
  logic [15:0] plen;
  logic [6:0]  pfx_add;
  logic [2:0]  pfx_len;
  logic        pfx_bad;
  logic        fatal;
  logic [2:0]  fatal_code;
  logic        msg_end;

  assign pos     = idx_q - HeaderLen;
  assign plen    = mlen_q - HeaderLen;
  assign pfx_add = {1'b0, in_byte_i[5:0]} + 7'd7;
  assign pfx_len = pfx_add[5:3];
  assign pfx_bad = in_byte_i > MaxPrefixLen;

  always_comb begin
    phase_d    = phase_q;
    idx_d      = idx_q;
    mlen_d     = mlen_q;
    typ_d      = typ_q;
    wlen_d     = wlen_q;
    alen_d     = alen_q;
    pleft_d    = pleft_q;
    wtally_d   = wtally_q;
    ntally_d   = ntally_q;
    status_d   = status_q;
    code_d     = code_q;
    as_d       = as_q;
    msg_tot_d  = msg_tot_q;
    upd_tot_d  = upd_tot_q;
    nlri_tot_d = nlri_tot_q;
    wdr_tot_d  = wdr_tot_q;
    halted_d   = halted_q;
    fatal      = 1'b0;
    fatal_code = StOk;
    msg_end    = 1'b0;
    res_vld_o  = 1'b0;
    res_o      = '0;

    if (in_vld_i && !halted_q) begin
      if (idx_q < 16'd16) begin
        if (in_byte_i != MarkerByte) begin
          fatal      = 1'b1;
          fatal_code = StBadMarker;
        end
      end else if (idx_q == 16'd16) begin
        mlen_d = {in_byte_i, 8'h00};
      end else if (idx_q == 16'd17) begin
        mlen_d = {mlen_q[15:8], in_byte_i};
        if (mlen_d < HeaderLen) begin
          fatal      = 1'b1;
          fatal_code = StShortLen;
        end
      end else if (idx_q == 16'd18) begin
        typ_d = in_byte_i;
        case (in_byte_i)
          TypeOpen: begin
            phase_d  = PhOpen;
            status_d = StBadVersion;
          end
          TypeUpdate: phase_d = PhWlen;
          TypeNotify: phase_d = PhNotify;
          default:    phase_d = PhSkip;
        endcase
      end else begin
        case (phase_q)
          PhOpen: begin
            if (pos == 16'd0) begin
              status_d = (in_byte_i == BgpVersion) ? StOk : StBadVersion;
            end else if (pos == 16'd1) begin
              as_d = {in_byte_i, as_q[7:0]};
            end else if (pos == 16'd2) begin
              as_d = {as_q[15:8], in_byte_i};
            end
          end
          PhNotify: begin
            if (pos == 16'd0) begin
              code_d = {in_byte_i, code_q[7:0]};
            end else if (pos == 16'd1) begin
              code_d = {code_q[15:8], in_byte_i};
            end
          end
          PhWlen: begin
            if (pos == 16'd0) begin
              wlen_d = {in_byte_i, 8'h00};
            end else begin
              wlen_d = {wlen_q[15:8], in_byte_i};
              if (17'(wlen_d) + 17'd2 > 17'(plen)) begin
                if (status_d == StOk) status_d = StWdrawOver;
                phase_d = PhSkip;
              end else if (wlen_d == 16'd0) begin
                phase_d = PhAlen;
              end else begin
                phase_d = PhWpfx;
              end
            end
          end
          PhWpfx: begin
            if (pleft_q != 3'd0) begin
              pleft_d = pleft_q - 3'd1;
            end else if (pfx_bad) begin
              if (status_d == StOk) status_d = StPrefixLen;
              phase_d = PhSkip;
            end else begin
              wtally_d = wtally_q + 16'd1;
              pleft_d  = pfx_len;
            end
            // last byte of the withdrawn region
            if (phase_d == PhWpfx && 17'(pos) == 17'(wlen_q) + 17'd1) begin
              if (pleft_d != 3'd0) begin
                if (status_d == StOk) status_d = StPrefixOver;
                phase_d = PhSkip;
              end else begin
                phase_d = PhAlen;
              end
            end
          end
          PhAlen: begin
            if (17'(pos) == 17'(wlen_q) + 17'd2) begin
              alen_d = {in_byte_i, 8'h00};
            end else begin
              alen_d = {alen_q[15:8], in_byte_i};
              if (18'(wlen_q) + 18'(alen_d) + 18'd4 > 18'(plen)) begin
                if (status_d == StOk) status_d = StAttrOver;
                phase_d = PhSkip;
              end else begin
                phase_d = (alen_d == 16'd0) ? PhNlri : PhAttr;
              end
            end
          end
          PhAttr: begin
            if (18'(pos) == 18'(wlen_q) + 18'(alen_q) + 18'd3) phase_d = PhNlri;
          end
          PhNlri: begin
            if (pleft_q != 3'd0) begin
              pleft_d = pleft_q - 3'd1;
            end else if (pfx_bad) begin
              if (status_d == StOk) status_d = StPrefixLen;
              phase_d = PhSkip;
            end else begin
              ntally_d = ntally_q + 16'd1;
              pleft_d  = pfx_len;
            end
          end
          default: ;
        endcase
      end

      msg_end = !fatal && (idx_q >= 16'd18) && (17'(idx_q) + 17'd1 == 17'(mlen_q));

      if (fatal) begin
        halted_d              = 1'b1;
        res_vld_o             = 1'b1;
        res_o.status          = fatal_code;
        res_o.total_messages  = 32'(msg_tot_q);
        res_o.total_updates   = 32'(upd_tot_q);
        res_o.total_nlri      = 32'(nlri_tot_q);
        res_o.total_withdrawn = 32'(wdr_tot_q);
      end else if (msg_end) begin
        // an update cut short takes the error of the region it stopped in
        if (typ_d == TypeUpdate && status_d == StOk) begin
          if (phase_d == PhWlen) begin
            status_d = StWdrawOver;
          end else if (phase_d == PhAlen || phase_d == PhAttr) begin
            status_d = StAttrOver;
          end else if (phase_d == PhNlri && pleft_d != 3'd0) begin
            status_d = StPrefixOver;
          end
        end
        msg_tot_d = msg_tot_q + TotalWidth'(1);
        if (typ_d == TypeUpdate && status_d == StOk) begin
          upd_tot_d  = upd_tot_q + TotalWidth'(1);
          nlri_tot_d = nlri_tot_q + TotalWidth'(ntally_d);
          wdr_tot_d  = wdr_tot_q + TotalWidth'(wtally_d);
        end
        res_vld_o             = 1'b1;
        res_o.msg_type        = typ_d;
        res_o.payload_length  = plen;
        res_o.status          = status_d;
        res_o.withdrawn_count = wtally_d;
        res_o.nlri_count      = ntally_d;
        res_o.notify_code     = code_d[15:8];
        res_o.notify_subcode  = code_d[7:0];
        res_o.open_as         = as_d;
        res_o.total_messages  = 32'(msg_tot_d);
        res_o.total_updates   = 32'(upd_tot_d);
        res_o.total_nlri      = 32'(nlri_tot_d);
        res_o.total_withdrawn = 32'(wdr_tot_d);
      end else begin
        idx_d = idx_q + 16'd1;
      end

      if (fatal || msg_end) begin
        phase_d  = PhHeader;
        idx_d    = '0;
        mlen_d   = '0;
        typ_d    = '0;
        wlen_d   = '0;
        alen_d   = '0;
        pleft_d  = '0;
        wtally_d = '0;
        ntally_d = '0;
        status_d = StOk;
        code_d   = '0;
        as_d     = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PhHeader;
      idx_q      <= '0;
      mlen_q     <= '0;
      typ_q      <= '0;
      wlen_q     <= '0;
      alen_q     <= '0;
      pleft_q    <= '0;
      wtally_q   <= '0;
      ntally_q   <= '0;
      status_q   <= StOk;
      code_q     <= '0;
      as_q       <= '0;
      msg_tot_q  <= '0;
      upd_tot_q  <= '0;
      nlri_tot_q <= '0;
      wdr_tot_q  <= '0;
      halted_q   <= 1'b0;
    end else begin
      phase_q    <= phase_d;
      idx_q      <= idx_d;
      mlen_q     <= mlen_d;
      typ_q      <= typ_d;
      wlen_q     <= wlen_d;
      alen_q     <= alen_d;
      pleft_q    <= pleft_d;
      wtally_q   <= wtally_d;
      ntally_q   <= ntally_d;
      status_q   <= status_d;
      code_q     <= code_d;
      as_q       <= as_d;
      msg_tot_q  <= msg_tot_d;
      upd_tot_q  <= upd_tot_d;
      nlri_tot_q <= nlri_tot_d;
      wdr_tot_q  <= wdr_tot_d;
      halted_q   <= halted_d;
    end
  end

  // once halted only reset brings the parser back
  a_halt_sticks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    halted_q |=> halted_q)
    else $error("parser left the halted state without reset");

  a_fatal_halts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_vld_o && (res_o.status == StBadMarker || res_o.status == StShortLen)
      && res_o.msg_type == 8'd0 && res_o.payload_length == 16'd0 |=> halted_q)
    else $error("header error did not halt the parser");

  a_payload_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q != PhHeader |-> idx_q >= HeaderLen)
    else $error("payload phase active inside the header");

  a_no_result_halted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    halted_q |-> !res_vld_o)
    else $error("result produced while halted");

endmodule

`default_nettype wire

[hdl/bgpmsp_out_buf.sv]
// result register with a skid stage in front of the output stream
`default_nettype none

module bgpmsp_out_buf (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push_i,
  input  wire bgpmsp_pkg::res_t   push_data_i,
  output logic                    full_o,
  output logic                    out_vld_o,
  input  wire logic               out_rdy_i,
  output bgpmsp_pkg::res_t        out_data_o
);
  import bgpmsp_pkg::*;

  logic out_vld_q;
  logic skd_vld_q;
  res_t out_q;
  res_t skd_q;
  logic pop;

  assign pop        = out_vld_q && out_rdy_i;
  assign full_o     = skd_vld_q;
  assign out_vld_o  = out_vld_q;
  assign out_data_o = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
      skd_vld_q <= 1'b0;
    end else begin
      if (!out_vld_q || pop) begin
        out_vld_q <= skd_vld_q || push_i;
        skd_vld_q <= 1'b0;
      end else if (push_i) begin
        skd_vld_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_vld_q || pop) begin
      out_q <= skd_vld_q ? skd_q : push_data_i;
    end else if (push_i) begin
      skd_q <= push_data_i;
    end
  end

  a_skid_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skd_vld_q |-> out_vld_q)
    else $error("skid stage holds a word while the output register is empty");

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !skd_vld_q)
    else $error("result pushed into a full buffer");

endmodule

`default_nettype wire

[hdl/bgp_message_stream_parser.sv]
// top level of the bgp message stream parser
`default_nettype none

// Takes one byte of a BGP TCP stream per clock while s_axis_tready_o is high and gives one
// result word on the last byte of each message (or on a fatal header error, after which it
// ignores input until reset). The parse state registers are written at the edge that
// accepts the byte; at that edge a finished result word goes into the result register,
// which drives m_axis_tvalid_o, or into the skid stage while the result register holds a
// word. The skid stage behind the result register keeps s_axis_tready_o high while a
// finished result waits; tready drops only when both the result register and the skid
// stage hold a word, and rises again in the cycle after the output takes a word.
module bgp_message_stream_parser (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  // data_byte [7:0]
  input  wire logic [7:0]                  s_axis_tdata_i,
  output logic                             m_axis_tvalid_o,
  input  wire logic                        m_axis_tready_i,
  // msg_type, payload_length, status, withdrawn_count, nlri_count, notify_code,
  // notify_subcode, open_as, total_messages, total_updates, total_nlri,
  // total_withdrawn, zero pad
  output logic [bgpmsp_pkg::DataW-1:0]     m_axis_tdata_o
);
  import bgpmsp_pkg::*;

  logic accept;
  logic full;
  logic res_vld;
  res_t res;
  res_t out_res;

  assign s_axis_tready_o = !full;
  assign accept          = s_axis_tvalid_i && !full;

  bgpmsp_step u_step (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_vld_i  (accept),
    .in_byte_i (s_axis_tdata_i),
    .res_vld_o (res_vld),
    .res_o     (res)
  );

  bgpmsp_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_vld),
    .push_data_i (res),
    .full_o      (full),
    .out_vld_o   (m_axis_tvalid_o),
    .out_rdy_i   (m_axis_tready_i),
    .out_data_o  (out_res)
  );

  assign m_axis_tdata_o = {{PadW{1'b0}}, out_res};

endmodule

`default_nettype wire

[verif/tb.sv]
// testbench for the bgp message stream parser: byte stream in, one checked word per message or header error
`timescale 1ns / 1ps

module tb;
  import bgpmsp_pkg::*;

  localparam int unsigned StallLimit = 2000;
  localparam int unsigned RandomBytes = 900;

  typedef enum logic [3:0] {
    PrsHeader, PrsSkip, PrsOpen, PrsNotify, PrsWdLen, PrsWdPfx, PrsAtLen, PrsAttr, PrsNlri
  } parse_phase_e;

  // pace selects the idling pattern used while the byte is offered
  typedef struct packed {
    logic [1:0] pace;
    logic [7:0] data;
  } stim_word_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic s_tvalid = 1'b0;
  logic [7:0] s_tdata = 8'h00;
  logic s_tready;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [DataW-1:0] m_tdata;

  bgp_message_stream_parser u_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata)
  );

  stim_word_t pending_bytes[$];
  res_t expected_results[$];
  logic [7:0] msg_body[$];
  int unsigned fill_pace = 0;
  int unsigned attr_pos;
  logic [1:0] cur_pace = 2'd0;
  int unsigned fail_count = 0;
  int unsigned stall_cycles = 0;

  // parser state mirrored by the predictor
  parse_phase_e phase_q;
  logic [15:0] byte_idx;
  logic [15:0] msg_len;
  logic [7:0] msg_type_q;
  logic [15:0] wd_len;
  logic [15:0] at_len;
  logic [2:0] pfx_left;
  logic [15:0] wd_tally;
  logic [15:0] nlri_tally;
  logic [2:0] status_q;
  logic [15:0] code_pair;
  logic [15:0] as_q;
  logic [TotalWidth-1:0] tot_msgs;
  logic [TotalWidth-1:0] tot_upd;
  logic [TotalWidth-1:0] tot_nlri;
  logic [TotalWidth-1:0] tot_wd;
  logic halted_q;

  initial begin
    forever #5 clk = ~clk;
  end

  task automatic clear_message();
    phase_q = PrsHeader;
    byte_idx = '0;
    msg_len = '0;
    msg_type_q = '0;
    wd_len = '0;
    at_len = '0;
    pfx_left = '0;
    wd_tally = '0;
    nlri_tally = '0;
    status_q = StOk;
    code_pair = '0;
    as_q = '0;
  endtask

  // first error sticks, rest of the payload is skipped
  task automatic fail_update(input logic [2:0] code);
    if (status_q == StOk) status_q = code;
    phase_q = PrsSkip;
  endtask

  task automatic count_prefix(input logic [7:0] b, inout logic [15:0] tally);
    if (pfx_left != 0) begin
      pfx_left = pfx_left - 3'd1;
    end else if (b > MaxPrefixLen) begin
      fail_update(StPrefixLen);
    end else begin
      tally = tally + 16'd1;
      pfx_left = 3'((b + 8'd7) >> 3);
    end
  endtask

  function automatic res_t pack_result(input logic [15:0] plen);
    res_t r;
    r.msg_type = msg_type_q;
    r.payload_length = plen;
    r.status = status_q;
    r.withdrawn_count = wd_tally;
    r.nlri_count = nlri_tally;
    r.notify_code = code_pair[15:8];
    r.notify_subcode = code_pair[7:0];
    r.open_as = as_q;
    r.total_messages = tot_msgs;
    r.total_updates = tot_upd;
    r.total_nlri = tot_nlri;
    r.total_withdrawn = tot_wd;
    return r;
  endfunction

  task automatic halt_parser(input logic [2:0] code);
    clear_message();
    status_q = code;
    expected_results.push_back(pack_result(16'd0));
    halted_q = 1'b1;
  endtask

  task automatic predict_byte(input logic [7:0] b);
    int unsigned idx;
    int unsigned p;
    int unsigned plen;
    if (!halted_q) begin
      idx = 32'(byte_idx);
      plen = 32'(msg_len) - 32'd19;
      p = idx - 32'd19;
      if (idx < 16) begin
        if (b != MarkerByte) halt_parser(StBadMarker);
      end else if (idx == 16) begin
        msg_len = {b, 8'h00};
      end else if (idx == 17) begin
        msg_len[7:0] = b;
        if (msg_len < HeaderLen) halt_parser(StShortLen);
      end else if (idx == 18) begin
        msg_type_q = b;
        if (b == TypeOpen) begin
          phase_q = PrsOpen;
          status_q = StBadVersion;
        end else if (b == TypeUpdate) begin
          phase_q = PrsWdLen;
        end else if (b == TypeNotify) begin
          phase_q = PrsNotify;
        end else begin
          phase_q = PrsSkip;
        end
      end else begin
        case (phase_q)
          PrsOpen: begin
            if (p == 0) status_q = (b == BgpVersion) ? StOk : StBadVersion;
            else if (p == 1) as_q[15:8] = b;
            else if (p == 2) as_q[7:0] = b;
          end
          PrsNotify: begin
            if (p == 0) code_pair[15:8] = b;
            else if (p == 1) code_pair[7:0] = b;
          end
          PrsWdLen: begin
            if (p == 0) begin
              wd_len = {b, 8'h00};
            end else begin
              wd_len[7:0] = b;
              if (32'(wd_len) + 32'd2 > plen) fail_update(StWdrawOver);
              else if (wd_len == 0) phase_q = PrsAtLen;
              else phase_q = PrsWdPfx;
            end
          end
          PrsWdPfx: begin
            count_prefix(b, wd_tally);
            if (phase_q == PrsWdPfx && p == 32'd1 + 32'(wd_len)) begin
              if (pfx_left != 0) fail_update(StPrefixOver);
              else phase_q = PrsAtLen;
            end
          end
          PrsAtLen: begin
            if (p == 32'd2 + 32'(wd_len)) begin
              at_len = {b, 8'h00};
            end else begin
              at_len[7:0] = b;
              if (32'(wd_len) + 32'(at_len) + 32'd4 > plen) fail_update(StAttrOver);
              else phase_q = (at_len == 0) ? PrsNlri : PrsAttr;
            end
          end
          PrsAttr: begin
            if (p == 32'd3 + 32'(wd_len) + 32'(at_len)) phase_q = PrsNlri;
          end
          PrsNlri: count_prefix(b, nlri_tally);
          default: ;
        endcase
      end
      if (!halted_q) begin
        if (idx < 18 || idx + 32'd1 != 32'(msg_len)) begin
          byte_idx = byte_idx + 16'd1;
        end else begin
          // an update cut short inside one of its regions
          if (msg_type_q == TypeUpdate && status_q == StOk) begin
            if (phase_q == PrsWdLen) status_q = StWdrawOver;
            else if (phase_q == PrsAtLen || phase_q == PrsAttr) status_q = StAttrOver;
            else if (phase_q == PrsNlri && pfx_left != 0) status_q = StPrefixOver;
          end
          tot_msgs = tot_msgs + 1'b1;
          if (msg_type_q == TypeUpdate && status_q == StOk) begin
            tot_upd = tot_upd + 1'b1;
            tot_nlri = tot_nlri + nlri_tally;
            tot_wd = tot_wd + wd_tally;
          end
          expected_results.push_back(pack_result(plen[15:0]));
          clear_message();
        end
      end
    end
  endtask

  task automatic put_byte(input logic [7:0] b);
    stim_word_t w;
    w.pace = fill_pace[1:0];
    w.data = b;
    pending_bytes.push_back(w);
  endtask

  task automatic put_message(input logic [7:0] msg_type);
    logic [15:0] len;
    len = 16'(19 + msg_body.size());
    repeat (16) put_byte(MarkerByte);
    put_byte(len[15:8]);
    put_byte(len[7:0]);
    put_byte(msg_type);
    foreach (msg_body[k]) put_byte(msg_body[k]);
    msg_body.delete();
  endtask

  task automatic add_prefix(input int unsigned len);
    msg_body.push_back(8'(len));
    repeat ((len + 7) / 8) msg_body.push_back(8'($urandom_range(255)));
  endtask

  task automatic add_prefixes(input int unsigned n);
    int unsigned cls;
    repeat (n) begin
      cls = $urandom_range(4);
      add_prefix((cls == 0) ? 0 : $urandom_range(8 * cls, 8 * cls - 7));
    end
  endtask

  task automatic build_update(input int unsigned n_wd, input int unsigned n_attr,
                              input int unsigned n_nlri);
    int unsigned wl;
    msg_body.delete();
    msg_body.push_back(8'h00);
    msg_body.push_back(8'h00);
    add_prefixes(n_wd);
    wl = msg_body.size() - 2;
    msg_body[0] = wl[15:8];
    msg_body[1] = wl[7:0];
    attr_pos = msg_body.size();
    msg_body.push_back(8'(n_attr >> 8));
    msg_body.push_back(8'(n_attr));
    repeat (n_attr) msg_body.push_back(8'($urandom_range(255)));
    add_prefixes(n_nlri);
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  // driver: one byte word per handshake, gaps by the pace of the next byte
  always @(posedge clk) begin
    if (rst_n) begin
      if (s_tvalid && s_tready) predict_byte(s_tdata);
      if (!s_tvalid || s_tready) begin
        if (pending_bytes.size() != 0 &&
            $urandom_range(99) >= ((pending_bytes[0].pace == 0) ? 15 :
                                   (pending_bytes[0].pace == 1) ? 74 : 0)) begin
          s_tdata <= pending_bytes[0].data;
          cur_pace <= pending_bytes[0].pace;
          s_tvalid <= 1'b1;
          void'(pending_bytes.pop_front());
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= ((cur_pace == 0) ? 74 : (cur_pace == 1) ? 15 : 0));
  end

  // monitor
  always @(posedge clk) begin
    res_t got;
    res_t want;
    if (rst_n && m_tvalid && m_tready) begin
      got = m_tdata[ResW-1:0];
      if (expected_results.size() == 0) begin
        $error("result word with nothing expected: type %0d status %0d",
               got.msg_type, got.status);
        fail_count++;
      end else begin
        want = expected_results.pop_front();
        check_field("msg_type", 32'(want.msg_type), 32'(got.msg_type));
        check_field("payload_length", 32'(want.payload_length), 32'(got.payload_length));
        check_field("status", 32'(want.status), 32'(got.status));
        check_field("withdrawn_count", 32'(want.withdrawn_count),
                    32'(got.withdrawn_count));
        check_field("nlri_count", 32'(want.nlri_count), 32'(got.nlri_count));
        check_field("notify_code", 32'(want.notify_code), 32'(got.notify_code));
        check_field("notify_subcode", 32'(want.notify_subcode), 32'(got.notify_subcode));
        check_field("open_as", 32'(want.open_as), 32'(got.open_as));
        check_field("total_messages", want.total_messages, got.total_messages);
        check_field("total_updates", want.total_updates, got.total_updates);
        check_field("total_nlri", want.total_nlri, got.total_nlri);
        check_field("total_withdrawn", want.total_withdrawn, got.total_withdrawn);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= StallLimit) begin
        $display("** bgp_message_stream_parser: FAILED **");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  initial begin
    int unsigned rand_start;
    int unsigned pick;
    int unsigned keep;
    int unsigned bad_pos;

    clear_message();
    tot_msgs = '0;
    tot_upd = '0;
    tot_nlri = '0;
    tot_wd = '0;
    halted_q = 1'b0;

    // directed messages
    fill_pace = 0;
    put_message(TypeKeepalive);
    msg_body = {BgpVersion, 8'hff, 8'hff, 8'h00, 8'hb4, 8'h0a, 8'h00, 8'h00, 8'h01, 8'h00};
    put_message(TypeOpen);
    // open with no payload reports a bad version
    put_message(TypeOpen);
    // wrong version, as low byte missing
    msg_body = {8'h03, 8'h80};
    put_message(TypeOpen);
    msg_body = {8'hff, 8'h00, 8'hde, 8'had};
    put_message(TypeNotify);
    msg_body = {8'h06};
    put_message(TypeNotify);
    msg_body = {8'h00, 8'h00, 8'h00, 8'h00};
    put_message(TypeUpdate);
    // every prefix size class, the classes above one byte at both ends
    msg_body = {8'h00, 8'd9};
    add_prefix(0);
    add_prefix(8);
    add_prefix(9);
    add_prefix(16);
    msg_body.push_back(8'h00);
    msg_body.push_back(8'h03);
    msg_body.push_back(8'h40);
    msg_body.push_back(8'h01);
    msg_body.push_back(8'h01);
    add_prefix(17);
    add_prefix(24);
    add_prefix(25);
    add_prefix(32);
    put_message(TypeUpdate);
    // prefix length above 32 in nlri and in withdrawn routes
    msg_body = {8'h00, 8'h00, 8'h00, 8'h00, 8'd33};
    put_message(TypeUpdate);
    msg_body = {8'h00, 8'h01, 8'hff, 8'h00, 8'h00};
    put_message(TypeUpdate);
    // nlri prefix cut by the message end
    msg_body = {8'h00, 8'h00, 8'h00, 8'h00, 8'd24, 8'haa};
    put_message(TypeUpdate);
    // withdrawn prefix running past its region
    msg_body = {8'h00, 8'h02, 8'd16, 8'h12, 8'h00, 8'h00, 8'h34};
    put_message(TypeUpdate);
    // withdrawn length field incomplete, then too large
    msg_body = {8'h00};
    put_message(TypeUpdate);
    msg_body = {8'hff, 8'hff, 8'h00, 8'h00};
    put_message(TypeUpdate);
    msg_body = {8'h00, 8'h03, 8'h00, 8'h00};
    put_message(TypeUpdate);
    // attribute length too large, then incomplete
    msg_body = {8'h00, 8'h00, 8'h00, 8'h10, 8'h01};
    put_message(TypeUpdate);
    msg_body = {8'h00, 8'h00, 8'h00};
    put_message(TypeUpdate);
    msg_body = {8'h01, 8'h02, 8'h03};
    put_message(8'h00);
    put_message(8'hff);

    // random messages, mostly updates, most of them well formed
    rand_start = pending_bytes.size();
    while (pending_bytes.size() - rand_start < RandomBytes) begin
      fill_pace = (pending_bytes.size() - rand_start) * 3 / RandomBytes;
      pick = $urandom_range(99);
      if (pick < 65) begin
        build_update($urandom_range(3), ($urandom_range(2) == 0) ? 0 : $urandom_range(8),
                     $urandom_range(4));
        if (pick >= 45) begin
          case ($urandom_range(4))
            0: begin
              msg_body[0] = 8'($urandom_range(255));
              msg_body[1] = 8'($urandom_range(255));
            end
            1: begin
              msg_body[attr_pos] = 8'($urandom_range(255));
              msg_body[attr_pos + 1] = 8'($urandom_range(255));
            end
            2: begin
              msg_body.push_back(8'($urandom_range(255, 33)));
              repeat ($urandom_range(3)) msg_body.push_back(8'($urandom_range(255)));
            end
            3: begin
              keep = $urandom_range(msg_body.size());
              while (msg_body.size() > keep) void'(msg_body.pop_back());
            end
            default: begin
              repeat ($urandom_range(3, 1)) msg_body.push_back(8'($urandom_range(255)));
            end
          endcase
        end
        put_message(TypeUpdate);
      end else if (pick < 75) begin
        if ($urandom_range(9) == 0) begin
          repeat ($urandom_range(2)) msg_body.push_back(8'($urandom_range(255)));
        end else begin
          msg_body.push_back(($urandom_range(4) == 0) ? 8'($urandom_range(255)) : BgpVersion);
          msg_body.push_back(8'($urandom_range(255)));
          msg_body.push_back(8'($urandom_range(255)));
          repeat ($urandom_range(7)) msg_body.push_back(8'($urandom_range(255)));
        end
        put_message(TypeOpen);
      end else if (pick < 85) begin
        if ($urandom_range(9) == 0) begin
          repeat ($urandom_range(1)) msg_body.push_back(8'($urandom_range(255)));
        end else begin
          repeat ($urandom_range(6, 2)) msg_body.push_back(8'($urandom_range(255)));
        end
        put_message(TypeNotify);
      end else if (pick < 90) begin
        put_message(TypeKeepalive);
      end else begin
        repeat ($urandom_range(6)) msg_body.push_back(8'($urandom_range(255)));
        put_message(8'($urandom_range(255)));
      end
    end

    // one long update with a withdrawn region of 100 prefixes, no idling
    fill_pace = 2;
    build_update(100, 40, 60);
    put_message(TypeUpdate);

    // fatal header error last, since only reset clears it
    if ($urandom_range(1) == 1) begin
      bad_pos = $urandom_range(15);
      repeat (bad_pos) put_byte(MarkerByte);
      put_byte(8'($urandom_range(254)));
    end else begin
      repeat (16) put_byte(MarkerByte);
      put_byte(8'h00);
      put_byte(8'($urandom_range(18)));
    end
    repeat (8) put_byte(8'($urandom_range(255)));

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_bytes.size() != 0 || s_tvalid) @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    if (fail_count == 0) begin
      $display("** bgp_message_stream_parser: PASSED **");
    end else begin
      $display("** bgp_message_stream_parser: FAILED **");
    end
    $finish;
  end

endmodule

[filelist.f]
hdl/bgpmsp_pkg.sv
hdl/bgpmsp_step.sv
hdl/bgpmsp_out_buf.sv
hdl/bgp_message_stream_parser.sv
verif/tb.sv
